// ===== rtl/rlm_pkg.sv =====
// Package for the RMS level meter: sizes, opcode and register codes, sequencer states.
// No dependencies; imported by rms_level_meter_core.
`default_nettype none

package rlm_pkg;

    // Longest fragment that is summed; later samples of a fragment are dropped.
    localparam int MAX_FRAGMENT = 4096;

    localparam int SAMPLE_W = 16;
    localparam int CNT_W    = $clog2(MAX_FRAGMENT + 1);
    // A square is at most 2^30, so the sum needs 30 bits plus the count width.
    localparam int SUM_W    = 30 + CNT_W;
    localparam int RMS_W    = 16;
    localparam int SCALE_W  = 16;
    localparam int LEVEL_W  = 32;
    localparam int PROD_W   = RMS_W + 1 + SCALE_W;
    localparam int SUB_W    = 19;
    localparam int ROOT_STEPS = 16;
    localparam int ITER_W   = $clog2(SUM_W + 1);

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    localparam logic REG_SCALE  = 1'b0;
    localparam logic REG_OFFSET = 1'b1;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_SQUARE = 7'b0000010,
        ST_ACCUM  = 7'b0000100,
        ST_DIVIDE = 7'b0001000,
        ST_ROOT   = 7'b0010000,
        ST_SCALE  = 7'b0100000,
        ST_LEVEL  = 7'b1000000
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/rms_level_meter_core.sv =====
// RMS level meter: sequencer around one shared multiplier and one shared subtractor.
// Depends on rlm_pkg.
`default_nettype none

// Usage
//   s_* channel: one request per audio sample or tick. s_tuser is the opcode
//   (0 = sample, 1 = tick), s_tdata the signed Q1.15 sample, s_tlast marks the
//   last sample of a fragment. m_* channel: one 32-bit level per tick.
//   cfg_* channel: register writes (0 = Q8.8 scale, 1 = offset); always ready.
// Timing
//   A sample is squared in the shared multiplier, then accumulated.
//   A sample with tlast then runs restoring division (one quotient bit a cycle
//   in the shared subtractor) and the square root (one root bit a cycle in the
//   same subtractor).
//   A tick is multiplied, then the offset is added and the result saturated.
//   s_tready is high only while the sequencer is idle.
// Stalls
//   The level sits in an output register, so new requests are taken while a
//   level waits; a following tick holds in its last step until the output
//   register is free.
// Reset
//   rst_n clears the sum, count and stored level, sets scale to 1.0, offset to 0.

module rms_level_meter_core
    import rlm_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [SAMPLE_W-1:0] s_tdata,   // [15:0] sample
    input  wire logic                s_tuser,   // [0] opcode
    input  wire logic                s_tlast,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [LEVEL_W-1:0]       m_tdata,   // [31:0] level
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic                cfg_index,
    input  wire logic [LEVEL_W-1:0]  cfg_data
);

    localparam logic signed [LEVEL_W+1:0] LV_MAX = 34'sh0_7FFF_FFFF;
    localparam logic signed [LEVEL_W+1:0] LV_MIN = 34'sh3_8000_0000;

    state_t                      state_reg, state_next;
    logic [SUM_W-1:0]            acc_reg, acc_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic [SUB_W-1:0]            rem_reg, rem_next;
    logic [RMS_W-1:0]            root_reg, root_next;
    logic [RMS_W-1:0]            rms_reg, rms_next;
    logic [ITER_W-1:0]           iter_reg, iter_next;
    logic signed [SAMPLE_W-1:0]  sample_reg, sample_next;
    logic                        last_reg, last_next;
    logic signed [PROD_W-1:0]    prod_reg, prod_next;
    logic [SCALE_W-1:0]          scale_reg;
    logic [LEVEL_W-1:0]          offset_reg;
    logic                        out_valid_reg, out_valid_next;
    logic [LEVEL_W-1:0]          out_data_reg, out_data_next;

    logic signed [RMS_W:0]       mul_a;
    logic signed [SCALE_W-1:0]   mul_b;
    logic signed [PROD_W-1:0]    mul_p;
    logic [SUB_W-1:0]            sub_a;
    logic [SUB_W-1:0]            sub_b;
    logic [SUB_W:0]              sub_diff;
    logic                        sub_borrow;
    logic signed [LEVEL_W+1:0]   level_sum;
    logic                        out_free;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign out_free  = !out_valid_reg || m_tready;

    // Shared multiplier: squares a sample, or scales the stored level.
    always_comb
    begin
        if (state_reg == ST_SCALE)
        begin
            mul_a = $signed({1'b0, rms_reg});
            mul_b = $signed(scale_reg);
        end
        else
        begin
            mul_a = (RMS_W + 1)'(sample_reg);
            mul_b = sample_reg;
        end
    end
    assign mul_p = mul_a * mul_b;

    // Shared subtractor: one division step or one square-root step per cycle.
    always_comb
    begin
        if (state_reg == ST_ROOT)
        begin
            sub_a = {rem_reg[SUB_W-3:0], acc_reg[31:30]};
            sub_b = {1'b0, root_reg, 2'b01};
        end
        else
        begin
            sub_a = SUB_W'({rem_reg[CNT_W-1:0], acc_reg[SUM_W-1]});
            sub_b = SUB_W'(count_reg);
        end
    end
    assign sub_diff   = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_borrow = sub_diff[SUB_W];

    // Floor shift of the scaled level, offset added, then saturated.
    assign level_sum = (LEVEL_W + 2)'(prod_reg >>> 8) + (LEVEL_W + 2)'($signed(offset_reg));

    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        count_next     = count_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        rms_next       = rms_reg;
        iter_next      = iter_reg;
        sample_next    = sample_reg;
        last_next      = last_reg;
        prod_next      = prod_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    sample_next = $signed(s_tdata);
                    last_next   = s_tlast;
                    if (s_tuser == OP_TICK)
                    begin
                        state_next = ST_SCALE;
                    end
                    else
                    begin
                        state_next = ST_SQUARE;
                    end
                end
            end
            ST_SQUARE:
            begin
                prod_next  = mul_p;
                state_next = ST_ACCUM;
            end
            ST_ACCUM:
            begin
                if (count_reg < CNT_W'(MAX_FRAGMENT))
                begin
                    acc_next   = acc_reg + SUM_W'(prod_reg[30:0]);
                    count_next = count_reg + CNT_W'(1);
                end
                // The count is at least one here, since the marked sample is
                // counted or the fragment is already full.
                if (last_reg)
                begin
                    rem_next   = '0;
                    iter_next  = ITER_W'(SUM_W);
                    state_next = ST_DIVIDE;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIVIDE:
            begin
                rem_next  = sub_borrow ? sub_a : sub_diff[SUB_W-1:0];
                acc_next  = {acc_reg[SUM_W-2:0], !sub_borrow};
                iter_next = iter_reg - ITER_W'(1);
                if (iter_reg == ITER_W'(1))
                begin
                    rem_next   = '0;
                    root_next  = '0;
                    iter_next  = ITER_W'(ROOT_STEPS);
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                rem_next  = sub_borrow ? sub_a : sub_diff[SUB_W-1:0];
                root_next = {root_reg[RMS_W-2:0], !sub_borrow};
                acc_next  = {acc_reg[SUM_W-3:0], 2'b00};
                iter_next = iter_reg - ITER_W'(1);
                if (iter_reg == ITER_W'(1))
                begin
                    rms_next   = {root_reg[RMS_W-2:0], !sub_borrow};
                    acc_next   = '0;
                    count_next = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_SCALE:
            begin
                prod_next  = mul_p;
                state_next = ST_LEVEL;
            end
            ST_LEVEL:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (level_sum > LV_MAX)
                    begin
                        out_data_next = LV_MAX[LEVEL_W-1:0];
                    end
                    else if (level_sum < LV_MIN)
                    begin
                        out_data_next = LV_MIN[LEVEL_W-1:0];
                    end
                    else
                    begin
                        out_data_next = level_sum[LEVEL_W-1:0];
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            acc_reg       <= '0;
            count_reg     <= '0;
            rem_reg       <= '0;
            root_reg      <= '0;
            rms_reg       <= '0;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            count_reg     <= count_next;
            rem_reg       <= rem_next;
            root_reg      <= root_next;
            rms_reg       <= rms_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg   <= sample_next;
        last_reg     <= last_next;
        prod_reg     <= prod_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg  <= SCALE_RESET;
            offset_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SCALE:  scale_reg  <= cfg_data[SCALE_W-1:0];
                REG_OFFSET: offset_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // The fragment count never passes the fragment limit.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_FRAGMENT))
        else $error("sample count above fragment limit");

    // A division partial remainder stays below the divisor.
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVIDE) |-> (rem_reg < SUB_W'(count_reg)))
        else $error("division remainder not below count");

    // The square root of a mean square of Q1.15 samples is at most 2^15.
    a_rms_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROOT && iter_reg == ITER_W'(1)) |=> (rms_reg <= 16'h8000))
        else $error("RMS level out of range");

    // An accepted tick goes to the scaling step next.
    a_tick_path: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == OP_TICK) |=> (state_reg == ST_SCALE))
        else $error("tick did not start scaling");

    // The sum and count are cleared when a fragment closes.
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROOT && iter_reg == ITER_W'(1)) |=> (acc_reg == '0 && count_reg == '0))
        else $error("accumulator not cleared at fragment end");

endmodule

`default_nettype wire
